// ===== rtl/core/utf8_code_point_range_filter_top_defines.svh =====
// Assertion macros shared by the filter RTL.
`ifndef UTF8_CODE_POINT_RANGE_FILTER_TOP_DEFINES_SVH
`define UTF8_CODE_POINT_RANGE_FILTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define UCPRF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UCPRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ucprf_pkg.sv =====
package ucprf_pkg;

    localparam int MAX_SEQ_BYTES_DEF = 8;
    localparam int CMD_DEPTH_DEF     = 4;

    localparam int CP_W       = 21;
    localparam int LEN_W      = 4;
    localparam int CONT_BITS  = 6;
    localparam int CFG_IDX_W  = 2;

    // longest sequence whose code point is range checked
    localparam logic [LEN_W-1:0] MAX_DROP_LEN = 4'd4;

    localparam logic [CP_W-1:0] RANGE_LOW_RESET  = 21'h1F300;
    localparam logic [CP_W-1:0] RANGE_HIGH_RESET = 21'h1F6FF;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } byte_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } result_word_t;

    // sequence length from the lead byte: 1 + ones after the top bit
    function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
        logic [LEN_W-1:0] len;
        unique casez (b)
            8'b0???????: len = 4'd1;
            8'b10??????: len = 4'd1;
            8'b110?????: len = 4'd2;
            8'b1110????: len = 4'd3;
            8'b11110???: len = 4'd4;
            8'b111110??: len = 4'd5;
            8'b1111110?: len = 4'd6;
            8'b11111110: len = 4'd7;
            8'b11111111: len = 4'd8;
            default:     len = 4'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] lead_mask(input logic [LEN_W-1:0] len);
        logic [7:0] m;
        unique case (len)
            4'd1:    m = 8'h3F;
            4'd2:    m = 8'h1F;
            4'd3:    m = 8'h0F;
            4'd4:    m = 8'h07;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/ucprf_front.sv =====
module ucprf_front #(
    parameter int MAX_SEQ_BYTES = ucprf_pkg::MAX_SEQ_BYTES_DEF,
    parameter int CMD_W = MAX_SEQ_BYTES * 8 + $clog2(MAX_SEQ_BYTES + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic                             cmd_full,
    input  ucprf_pkg::byte_word_t            byte_word,
    input  logic                             wr_en,
    input  logic [ucprf_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [ucprf_pkg::CP_W-1:0]       wr_data,
    output logic                             cmd_push,
    output logic [CMD_W-1:0]                 cmd_data
);
    import ucprf_pkg::*;

    localparam int IDX_W = $clog2(MAX_SEQ_BYTES);
    localparam int CNT_W = $clog2(MAX_SEQ_BYTES + 1);
    localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_SEQ_BYTES);

    logic [CP_W-1:0]  range_low_reg;
    logic [CP_W-1:0]  range_high_reg;
    logic [LEN_W-1:0] exp_reg, exp_next;
    logic [LEN_W-1:0] held_reg, held_next;
    logic [CP_W-1:0]  acc_reg, acc_next;
    logic [7:0]       buf_reg [MAX_SEQ_BYTES];

    logic             accept;
    logic [7:0]       b;
    logic             eos;
    logic             idle;
    logic             ascii;
    logic             thru_start;
    logic             thru_cont;
    logic [LEN_W-1:0] len_in;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] n_new;
    logic [IDX_W-1:0] pos;
    logic [CP_W-1:0]  acc_new;
    logic             complete;
    logic             in_range;
    logic             buf_we;
    logic [7:0]       merged [MAX_SEQ_BYTES];
    logic [CNT_W-1:0] cmd_count;

    assign accept     = push && !cmd_full;
    assign b          = byte_word.data_byte;
    assign eos        = byte_word.end_of_stream;
    assign idle       = (exp_reg == '0);
    assign ascii      = idle && !b[7];
    assign len_in     = lead_length(b);
    assign thru_start = idle && b[7] && (len_in > MAXL);
    assign thru_cont  = (exp_reg > MAXL);
    assign pos        = (idle || thru_cont) ? '0 : held_reg[IDX_W-1:0];
    assign n_new      = idle ? LEN_W'(1) : held_reg + LEN_W'(1);
    assign len_eff    = idle ? len_in : exp_reg;
    assign acc_new    = idle ? CP_W'(b & lead_mask(len_in))
                             : {acc_reg[CP_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
    assign complete   = (n_new >= len_eff);
    assign in_range   = (len_eff <= MAX_DROP_LEN) && (acc_new >= range_low_reg)
                        && (acc_new <= range_high_reg);

    always_comb
    begin
        for (int k = 0; k < MAX_SEQ_BYTES; k++)
        begin
            merged[k] = buf_reg[k];
        end
        merged[pos] = b;
    end

    always_comb
    begin
        for (int k = 0; k < MAX_SEQ_BYTES; k++)
        begin
            cmd_data[k*8 +: 8] = merged[k];
        end
        cmd_data[CMD_W-1 -: CNT_W] = cmd_count;
    end

    always_comb
    begin
        exp_next  = exp_reg;
        held_next = held_reg;
        acc_next  = acc_reg;
        cmd_push  = 1'b0;
        cmd_count = CNT_W'(1);
        buf_we    = 1'b0;
        if (accept)
        begin
            if (ascii)
            begin
                cmd_push = 1'b1;
            end
            else if (thru_start)
            begin
                cmd_push = 1'b1;
                if (!eos)
                begin
                    exp_next  = len_in;
                    held_next = LEN_W'(1);
                    acc_next  = '0;
                end
            end
            else if (thru_cont)
            begin
                cmd_push  = 1'b1;
                held_next = n_new;
                if (eos || (n_new >= exp_reg))
                begin
                    exp_next  = '0;
                    held_next = '0;
                    acc_next  = '0;
                end
            end
            else
            begin
                buf_we    = 1'b1;
                cmd_count = CNT_W'(n_new);
                if (complete || eos)
                begin
                    cmd_push  = !(complete && in_range);
                    exp_next  = '0;
                    held_next = '0;
                    acc_next  = '0;
                end
                else
                begin
                    exp_next  = len_eff;
                    held_next = n_new;
                    acc_next  = acc_new;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg        <= '0;
            held_reg       <= '0;
            acc_reg        <= '0;
            range_low_reg  <= RANGE_LOW_RESET;
            range_high_reg <= RANGE_HIGH_RESET;
        end
        else
        begin
            exp_reg  <= exp_next;
            held_reg <= held_next;
            acc_reg  <= acc_next;
            if (wr_en)
            begin
                case (wr_index)
                    REG_RANGE_LOW:  range_low_reg  <= wr_data;
                    REG_RANGE_HIGH: range_high_reg <= wr_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_reg[pos] <= b;
        end
    end

`include "utf8_code_point_range_filter_top_defines.svh"

    `UCPRF_ASSERT_NEXT(a_eos_closes, accept && eos, exp_reg == '0, "sequence open after end of stream")
    `UCPRF_ASSERT_NOW(a_held_bound, (exp_reg != '0) && (exp_reg <= MAXL), (held_reg != '0) && (held_reg < exp_reg), "held count out of bounds")
    `UCPRF_ASSERT_NOW(a_push_count, cmd_push, (cmd_count != '0) && (cmd_count <= CNT_W'(MAX_SEQ_BYTES)), "bad word count")

endmodule

// ===== rtl/core/ucprf_cmd_fifo.sv =====
module ucprf_cmd_fifo #(
    parameter int CMD_W = 68,
    parameter int DEPTH = ucprf_pkg::CMD_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_push,
    input  logic [CMD_W-1:0] wr_data,
    output logic             full,
    input  logic             rd_pop,
    output logic             rd_valid,
    output logic [CMD_W-1:0] rd_data
);
    import ucprf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CMD_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_push && !full;
    assign do_rd    = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/ucprf_back.sv =====
module ucprf_back #(
    parameter int MAX_SEQ_BYTES = ucprf_pkg::MAX_SEQ_BYTES_DEF,
    parameter int CMD_W = MAX_SEQ_BYTES * 8 + $clog2(MAX_SEQ_BYTES + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  logic [CMD_W-1:0]        cmd_data,
    output logic                    cmd_pop,
    output logic                    empty,
    input  logic                    pop,
    output ucprf_pkg::result_word_t result_word
);
    import ucprf_pkg::*;

    localparam int IDX_W = $clog2(MAX_SEQ_BYTES);
    localparam int CNT_W = $clog2(MAX_SEQ_BYTES + 1);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] head_cnt;
    logic             last;
    logic             pop_fire;

    assign head_cnt = cmd_data[CMD_W-1 -: CNT_W];
    assign last     = ((CNT_W'(idx_reg) + CNT_W'(1)) == head_cnt);
    assign pop_fire = pop && cmd_valid;
    assign empty    = !cmd_valid;
    assign cmd_pop  = pop_fire && last;

    assign result_word.out_byte = cmd_data[idx_reg*8 +: 8];
    assign result_word.run_last = last;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop_fire)
        begin
            idx_next = last ? '0 : idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

`include "utf8_code_point_range_filter_top_defines.svh"

    `UCPRF_ASSERT_NOW(a_idx_in_word, cmd_valid, (CNT_W'(idx_reg) < head_cnt), "byte index past word count")
    `UCPRF_ASSERT_NEXT(a_idx_rewind, pop_fire && last, idx_reg == '0, "index not rewound after last byte")
    `UCPRF_ASSERT_NOW(a_idle_idx, !cmd_valid, idx_reg == '0, "index moved with no word queued")

endmodule

// ===== rtl/core/utf8_code_point_range_filter_top.sv =====
// Timing: the word for a byte that closes a kept sequence is written to the word queue as
// the byte is accepted; a kept sequence of n bytes then drains at one byte per cycle while pop is high.
// Throughput: one byte per cycle in while full is low, and out while pop is high; a 4-entry word
// queue between the classifier and the byte serializer absorbs output stalls before full rises.
// Reset: rst_n clears sequence state, queue and serializer; range registers return
// to 0x1F300..0x1F6FF.
module utf8_code_point_range_filter_top #(
    parameter int MAX_SEQ_BYTES = ucprf_pkg::MAX_SEQ_BYTES_DEF,
    parameter int CMD_DEPTH     = ucprf_pkg::CMD_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  ucprf_pkg::byte_word_t            byte_word,
    output logic                             empty,
    input  logic                             pop,
    output ucprf_pkg::result_word_t          result_word,
    input  logic                             wr_en,
    input  logic [ucprf_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [ucprf_pkg::CP_W-1:0]       wr_data
);
    import ucprf_pkg::*;

    localparam int CMD_W = MAX_SEQ_BYTES * 8 + $clog2(MAX_SEQ_BYTES + 1);

    logic             cmd_push;
    logic [CMD_W-1:0] cmd_wr_data;
    logic             cmd_full;
    logic             cmd_pop;
    logic             cmd_valid;
    logic [CMD_W-1:0] cmd_rd_data;

    assign full = cmd_full;

    ucprf_front #(
        .MAX_SEQ_BYTES(MAX_SEQ_BYTES),
        .CMD_W(CMD_W)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .cmd_full(cmd_full),
        .byte_word(byte_word),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data),
        .cmd_push(cmd_push),
        .cmd_data(cmd_wr_data)
    );

    ucprf_cmd_fifo #(
        .CMD_W(CMD_W),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_fifo (
        .clk(clk),
        .rst_n(rst_n),
        .wr_push(cmd_push),
        .wr_data(cmd_wr_data),
        .full(cmd_full),
        .rd_pop(cmd_pop),
        .rd_valid(cmd_valid),
        .rd_data(cmd_rd_data)
    );

    ucprf_back #(
        .MAX_SEQ_BYTES(MAX_SEQ_BYTES),
        .CMD_W(CMD_W)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_data(cmd_rd_data),
        .cmd_pop(cmd_pop),
        .empty(empty),
        .pop(pop),
        .result_word(result_word)
    );

endmodule

// ===== tb/tb_utf8_code_point_range_filter_top.sv =====
`timescale 1ns / 100ps

module tb_utf8_code_point_range_filter_top;
    import ucprf_pkg::*;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_ECHO
    } row_chk_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        row_chk_t   chk;
    } dir_row_t;

    // default range 0x1F300..0x1F6FF
    localparam dir_row_t DIR_ROWS [24] = '{
        '{8'h00, 1'b0, CHK_ECHO},
        '{8'h7F, 1'b0, CHK_ECHO},
        '{8'h41, 1'b1, CHK_ECHO},
        // U+1F600, dropped
        '{8'hF0, 1'b0, CHK_NONE},
        '{8'h9F, 1'b0, CHK_NONE},
        '{8'h98, 1'b0, CHK_NONE},
        '{8'h80, 1'b0, CHK_NONE},
        // U+1F300, low edge, dropped
        '{8'hF0, 1'b0, CHK_NONE},
        '{8'h9F, 1'b0, CHK_NONE},
        '{8'h8C, 1'b0, CHK_NONE},
        '{8'h80, 1'b0, CHK_NONE},
        // U+1F6FF, high edge, dropped
        '{8'hF0, 1'b0, CHK_NONE},
        '{8'h9F, 1'b0, CHK_NONE},
        '{8'h9B, 1'b0, CHK_NONE},
        '{8'hBF, 1'b0, CHK_NONE},
        // U+1F700, just above, kept
        '{8'hF0, 1'b0, CHK_NONE},
        '{8'h9F, 1'b0, CHK_NONE},
        '{8'h9C, 1'b0, CHK_NONE},
        '{8'h80, 1'b0, CHK_PREDICT},
        '{8'hC3, 1'b0, CHK_NONE},
        '{8'hA9, 1'b0, CHK_PREDICT},
        // lone continuation byte
        '{8'h80, 1'b0, CHK_ECHO},
        // five byte lead cut short by stream end
        '{8'hF8, 1'b0, CHK_NONE},
        '{8'h80, 1'b1, CHK_PREDICT}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    byte_word_t           byte_word;
    logic                 empty;
    logic                 pop;
    result_word_t         result_word;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CP_W-1:0]      wr_data;

    logic [7:0]   seq_bytes [8];
    int unsigned  seq_len;
    int unsigned  seq_held;
    logic [47:0]  seq_cp;
    logic [20:0]  drop_lo;
    logic [20:0]  drop_hi;
    result_word_t step_out [$];
    result_word_t kept_q [$];
    result_word_t want;
    int unsigned  bytes_sent;
    int unsigned  errors;
    bit           gap_en;
    bit           stall_en;

    utf8_code_point_range_filter_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .byte_word   (byte_word),
        .empty       (empty),
        .pop         (pop),
        .result_word (result_word),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned count_lead_ones(input logic [7:0] b);
        int unsigned n;
        int          i;
        n = 1;
        i = 6;
        if (b[7])
        begin
            while (i >= 0 && b[i])
            begin
                n++;
                i--;
            end
        end
        return n;
    endfunction

    function automatic logic [7:0] lead_payload_mask(input int unsigned len);
        case (len)
            1:       return 8'h3F;
            2:       return 8'h1F;
            3:       return 8'h0F;
            4:       return 8'h07;
            default: return 8'h00;
        endcase
    endfunction

    task automatic add_out(input logic [7:0] b, input logic last);
        result_word_t r;
        r.out_byte = b;
        r.run_last = last;
        step_out.insert(step_out.size(), r);
    endtask

    task automatic flush_held();
        for (int k = 0; k < seq_held; k++)
            add_out(seq_bytes[k], k + 1 == seq_held);
    endtask

    // words released by one input byte, left in step_out
    task automatic filter_byte(input logic [7:0] b, input logic eos);
        step_out.delete();
        if (seq_len == 0)
        begin
            if (!b[7])
            begin
                add_out(b, 1'b1);
                return;
            end
            seq_len = count_lead_ones(b);
            seq_held = 1;
            seq_bytes[0] = b;
            seq_cp = 48'(b & lead_payload_mask(seq_len));
        end
        else
        begin
            seq_bytes[seq_held] = b;
            seq_held++;
            seq_cp = {seq_cp[41:0], b[5:0]};
        end
        if (seq_held >= seq_len)
        begin
            if (!(seq_len <= MAX_DROP_LEN && seq_cp >= drop_lo && seq_cp <= drop_hi))
                flush_held();
            seq_len = 0;
            seq_held = 0;
            seq_cp = '0;
        end
        else if (eos)
        begin
            flush_held();
            seq_len = 0;
            seq_held = 0;
            seq_cp = '0;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eos, input row_chk_t chk);
        byte_word_t   w;
        result_word_t r;
        if (gap_en && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        w.data_byte = b;
        w.end_of_stream = eos;
        push <= 1'b1;
        byte_word <= w;
        @(posedge clk);
        while (full) @(posedge clk);
        filter_byte(b, eos);
        case (chk)
            CHK_NONE:
            begin
            end
            CHK_ECHO:
            begin
                r.out_byte = b;
                r.run_last = 1'b1;
                kept_q.insert(kept_q.size(), r);
            end
            default:
            begin
                foreach (step_out[k]) kept_q.insert(kept_q.size(), step_out[k]);
            end
        endcase
        bytes_sent++;
    endtask

    // mostly well-formed sequences, code points at the drop range edges, inside it or random
    task automatic send_sequence();
        int unsigned kind;
        int unsigned n;
        logic [20:0] cp;
        logic [7:0]  part [8];
        kind = $urandom_range(0, 9);
        case ($urandom_range(0, 2))
            0:       cp = ($urandom_range(0, 1) ? drop_lo : drop_hi)
                          + 21'($urandom_range(0, 4)) - 21'd2;
            1:       cp = 21'($urandom);
            default: cp = (drop_lo <= drop_hi)
                          ? drop_lo + 21'($urandom_range(0, drop_hi - drop_lo))
                          : 21'($urandom);
        endcase
        if (kind < 2)
        begin
            n = 1;
            part[0] = 8'($urandom_range(0, 127));
        end
        else if (kind < 9)
        begin
            n = (kind == 8) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            part[0] = 8'(8'hFF << (8 - n))
                      | (8'(n <= 4 ? cp >> (6 * (n - 1)) : $urandom)
                         & 8'(8'hFF >> (n + 1)));
            for (int k = 1; k < n; k++)
                part[k] = (n > 4 || $urandom_range(0, 7) == 0) ? 8'($urandom)
                          : {2'b10, 6'(cp >> (6 * (n - 1 - k)))};
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
                part[k] = 8'($urandom);
        end
        for (int k = 0; k < n; k++)
            send_byte(part[k], $urandom_range(0, 15) == 0, CHK_PREDICT);
    endtask

    // closes with an end-of-stream byte so no sequence stays open
    task automatic run_phase(input int unsigned count);
        int unsigned stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_sequence();
        send_byte(8'($urandom), 1'b1, CHK_PREDICT);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (kept_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_range(input logic [20:0] lo, input logic [20:0] hi);
        wr_en <= 1'b1;
        wr_index <= REG_RANGE_LOW;
        wr_data <= lo;
        @(posedge clk);
        wr_index <= REG_RANGE_HIGH;
        wr_data <= hi;
        @(posedge clk);
        wr_en <= 1'b0;
        drop_lo = lo;
        drop_hi = hi;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (kept_q.size() == 0)
            begin
                $error("unexpected word: out_byte %h run_last %b",
                       result_word.out_byte, result_word.run_last);
                errors++;
            end
            else
            begin
                want = kept_q.pop_front();
                if (result_word.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, result_word.out_byte);
                    errors++;
                end
                if (result_word.run_last !== want.run_last)
                begin
                    $error("run_last: expected %b, got %b", want.run_last, result_word.run_last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int unsigned stall_left;
        pop = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_en && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 10);
            if (stall_en && stall_left != 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                stall_left = 0;
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [20:0] lo;
        rst_n = 1'b0;
        push = 1'b0;
        byte_word = '0;
        wr_en = 1'b0;
        wr_index = REG_RANGE_LOW;
        wr_data = '0;
        gap_en = 1'b1;
        stall_en = 1'b1;
        errors = 0;
        bytes_sent = 0;
        seq_len = 0;
        seq_held = 0;
        seq_cp = '0;
        drop_lo = RANGE_LOW_RESET;
        drop_hi = RANGE_HIGH_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[i])
            send_byte(DIR_ROWS[i].data, DIR_ROWS[i].eos, DIR_ROWS[i].chk);
        run_phase(20);
        drain();
        run_phase(20);
        drain();

        set_range(21'h000000, 21'h1FFFFF);
        run_phase(35);
        drain();
        // inverted range
        set_range(21'h1FFFFF, 21'h000000);
        run_phase(25);
        drain();
        set_range(21'h000000, 21'h00003F);
        run_phase(25);
        drain();
        set_range(21'h000080, 21'h0007FF);
        run_phase(25);
        drain();

        gap_en = 1'b0;
        stall_en = 1'b0;
        lo = 21'($urandom);
        set_range(lo, lo + 21'($urandom_range(0, 4095)));
        run_phase(35);
        drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
